// ===== hw/rtl/page_framebuffer_pixel_writer_unit_assert.svh =====
// Assertion macros used by the checker file of the pixel writer.
`ifndef PAGE_FRAMEBUFFER_PIXEL_WRITER_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define PFPW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel writer check failed");

// Next-cycle implication, checked only outside reset.
`define PFPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel writer check failed");

`endif

// ===== hw/rtl/pfpw_pkg.sv =====
package pfpw_pkg;

  // Display pages, eight pixel rows each.
  localparam int unsigned PAGE_COUNT = 8;

  localparam logic [7:0] PAGE_BASE     = 8'hB0;
  localparam logic [4:0] COL_HIGH_BASE = 5'h10;
  localparam logic [7:0] FILL_BLACK    = 8'h00;
  localparam logic [7:0] FILL_WHITE    = 8'hFF;

  localparam logic CMD_PLOT  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] x;
    logic [7:0] y;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] page_command;
    logic [3:0] column_low_command;
    logic [4:0] column_high_command;
    logic [7:0] data_byte;
    logic [7:0] repeat_count;
    logic       last;
  } out_item_t;

endpackage

// ===== hw/rtl/pfpw_shadow_mem.sv =====
module pfpw_shadow_mem #(
  parameter int unsigned DEPTH  = 768,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/page_framebuffer_pixel_writer_unit.sv =====
// Plot item: the memory read is issued at acceptance; modify, write back
// and the load of the output register follow in ST_READ once the output is free.
// No new item is taken until the plot has left ST_READ.
// Clear item: a sweep writes the fill byte to every shadow memory entry, then
// eight page results follow, one per cycle while the output is not stalled.
// Reset: a clearing pass zeros the shadow memory; no item before it ends.
module page_framebuffer_pixel_writer_unit #(
  parameter int unsigned DISPLAY_WIDTH      = 96,
  parameter int unsigned DISPLAY_HEIGHT     = 64,
  parameter int unsigned COLUMN_OFFSET      = 18,
  parameter int unsigned CONTROLLER_COLUMNS = 132
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfpw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfpw_pkg::out_item_t out_data
);

  import pfpw_pkg::*;

  // The shadow store holds one byte per column of each page, page-major.
  localparam int unsigned STORE_DEPTH = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [8:0] X_LIMIT = 9'(DISPLAY_WIDTH);
  localparam logic [8:0] Y_LIMIT = 9'(DISPLAY_HEIGHT);
  localparam logic [2:0] LAST_PAGE = 3'(PAGE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_SWEEP,  // writing the fill byte to every entry
    ST_IDLE,   // ready for an item
    ST_READ,   // read data of a plot is back; modify and write it
    ST_PAGES   // handing out the eight page results of a clear
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic              emit_r, emit_nxt;
  logic [2:0]        page_r, page_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic              color_r, color_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              in_range;
  logic [2:0]        in_page;
  logic [ADDR_W-1:0] plot_addr;
  logic              out_free;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic [7:0]        new_byte;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = (9'(in_data.x) < X_LIMIT) && (9'(in_data.y) < Y_LIMIT);
  // Rows stop below 64, so the page is simply the upper row bits.
  assign in_page   = in_data.y[5:3];
  assign plot_addr = ADDR_W'(32'(in_page) * 32'(DISPLAY_WIDTH) + 32'(in_data.x));

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Plot reads at acceptance; the write back happens in ST_READ, so a read
  // and a write of the same entry never fall in the same cycle.
  assign mem_re   = accept && (in_data.command == CMD_PLOT) && in_range;
  assign new_byte = color_r ? (mem_rdata | mask_r) : (mem_rdata & ~mask_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_r;
    case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = fill_r;
      end
      ST_READ: begin
        mem_we    = out_free;
        mem_wdata = new_byte;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pfpw_shadow_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (addr_r),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (plot_addr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    fill_nxt      = fill_r;
    emit_nxt      = emit_r;
    page_nxt      = page_r;
    col_nxt       = col_r;
    mask_nxt      = mask_r;
    color_nxt     = color_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_SWEEP: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt = '0;
          page_nxt = '0;
          // After reset the sweep is silent; after a clear the pages follow.
          state_nxt = emit_r ? ST_PAGES : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_CLEAR) begin
            fill_nxt  = in_data.color ? FILL_WHITE : FILL_BLACK;
            emit_nxt  = 1'b1;
            addr_nxt  = '0;
            state_nxt = ST_SWEEP;
          end else if (in_range) begin
            // Out-of-range plots are dropped here without a result.
            addr_nxt  = plot_addr;
            page_nxt  = in_page;
            col_nxt   = in_data.x + 8'(COLUMN_OFFSET);
            mask_nxt  = 8'(1) << in_data.y[2:0];
            color_nxt = in_data.color;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt                    = 1'b1;
          out_data_nxt.page_command        = PAGE_BASE | {5'b0, page_r};
          out_data_nxt.column_low_command  = col_r[3:0];
          out_data_nxt.column_high_command = COL_HIGH_BASE | {1'b0, col_r[7:4]};
          out_data_nxt.data_byte           = new_byte;
          out_data_nxt.repeat_count        = 8'd1;
          out_data_nxt.last                = 1'b1;
          state_nxt                        = ST_IDLE;
        end
      end
      ST_PAGES: begin
        if (out_free) begin
          out_valid_nxt                    = 1'b1;
          out_data_nxt.page_command        = PAGE_BASE | {5'b0, page_r};
          out_data_nxt.column_low_command  = 4'd0;
          out_data_nxt.column_high_command = COL_HIGH_BASE;
          out_data_nxt.data_byte           = fill_r;
          out_data_nxt.repeat_count        = 8'(CONTROLLER_COLUMNS);
          out_data_nxt.last                = (page_r == LAST_PAGE);
          page_nxt                         = page_r + 1'b1;
          if (page_r == LAST_PAGE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      addr_r      <= '0;
      fill_r      <= FILL_BLACK;
      emit_r      <= 1'b0;
      page_r      <= '0;
      col_r       <= '0;
      mask_r      <= '0;
      color_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      fill_r      <= fill_nxt;
      emit_r      <= emit_nxt;
      page_r      <= page_nxt;
      col_r       <= col_nxt;
      mask_r      <= mask_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pfpw_checker.sv =====
`include "page_framebuffer_pixel_writer_unit_assert.svh"

module pfpw_checker #(
  parameter int unsigned CONTROLLER_COLUMNS = 132
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pfpw_pkg::out_item_t out_data
);

  import pfpw_pkg::*;

  localparam logic [7:0] CLEAR_REPEAT = 8'(CONTROLLER_COLUMNS);

  // A stalled result stays offered and unchanged.
  `PFPW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Every result addresses one of the eight pages.
  `PFPW_ASSERT_NOW(a_page_cmd, out_valid, out_data.page_command[7:3] == PAGE_BASE[7:3])

  // A result is either a single plotted byte or a full page fill.
  `PFPW_ASSERT_NOW(a_repeat, out_valid, (out_data.repeat_count == 8'd1) || (out_data.repeat_count == CLEAR_REPEAT))

  // The last page of a clear carries the end mark.
  `PFPW_ASSERT_NOW(a_last_page, out_valid && (out_data.repeat_count != 8'd1) && (out_data.page_command == (PAGE_BASE | 8'h07)), out_data.last)

endmodule

bind page_framebuffer_pixel_writer_unit pfpw_checker #(
  .CONTROLLER_COLUMNS(CONTROLLER_COLUMNS)
) u_pfpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pfpw_pkg::*;

  // Geometry of the display under test. The instance gets the same values
  // explicitly, so the shadow copy below always matches the hardware.
  localparam int unsigned DISP_W      = 96;
  localparam int unsigned DISP_H      = 64;
  localparam int unsigned COL_OFFSET  = 18;
  localparam int unsigned CTRL_COLS   = 132;
  localparam int unsigned FRAME_BYTES = PAGE_COUNT * DISP_W;

  // A clear sweeps all FRAME_BYTES entries before its first page write, and
  // each write may then wait out a long receiver stall. The reset clearing
  // pass takes the same time. The limit is several times the worst of these.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned RANDOM_ITEMS   = 205;

  // Holds the expected page writes and a private copy of the frame. Each
  // accepted item updates the frame copy in acceptance order and queues the
  // writes it must cause; each accepted result is matched to the oldest one.
  class shadow_scoreboard;
    logic [7:0]  frame [FRAME_BYTES];
    out_item_t   pending_writes [$];
    int unsigned mismatches;
    int unsigned matched;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      mismatches = 0;
      matched    = 0;
    endfunction

    function void queue_write(logic [2:0] page, logic [7:0] col, logic [7:0] data,
                              logic [7:0] reps, logic last);
      out_item_t w;
      w.page_command        = PAGE_BASE + {5'b0, page};
      w.column_low_command  = col[3:0];
      w.column_high_command = COL_HIGH_BASE | {1'b0, col[7:4]};
      w.data_byte           = data;
      w.repeat_count        = reps;
      w.last                = last;
      pending_writes.push_back(w);
    endfunction

    function void apply_item(in_item_t it);
      logic [7:0]  fill;
      logic [2:0]  page;
      logic [7:0]  col;
      int unsigned idx;
      int          p;
      if (it.command == CMD_CLEAR) begin
        // Clear writes every page from controller column zero, no offset.
        fill = it.color ? FILL_WHITE : FILL_BLACK;
        for (p = 0; p < PAGE_COUNT; p++) begin
          queue_write(3'(p), 8'h00, fill, 8'(CTRL_COLS), p == PAGE_COUNT - 1);
        end
        foreach (frame[i]) frame[i] = fill;
      end else if (it.x < DISP_W && it.y < DISP_H) begin
        page = it.y[5:3];
        idx  = page * DISP_W + it.x;
        frame[idx][it.y[2:0]] = it.color;
        col = it.x + 8'(COL_OFFSET);
        queue_write(page, col, frame[idx], 8'd1, 1'b1);
      end
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_write(out_item_t got);
      out_item_t want;
      bit        ok;
      if (pending_writes.size() == 0) begin
        $error("unexpected page write: page_command %0h data_byte %0h",
               got.page_command, got.data_byte);
        mismatches++;
        return;
      end
      want = pending_writes.pop_front();
      ok = 1'b1;
      ok &= field_ok("page_command", 32'(want.page_command), 32'(got.page_command));
      ok &= field_ok("column_low_command", 32'(want.column_low_command),
                     32'(got.column_low_command));
      ok &= field_ok("column_high_command", 32'(want.column_high_command),
                     32'(got.column_high_command));
      ok &= field_ok("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      ok &= field_ok("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
      ok &= field_ok("last", 32'(want.last), 32'(got.last));
      if (ok) matched++;
      else mismatches++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  shadow_scoreboard board;

  // When calm is set, neither side idles, which gives back-to-back stretches.
  bit          calm = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned n_plot = 0;
  int unsigned n_clear = 0;
  int unsigned n_ignored = 0;

  page_framebuffer_pixel_writer_unit #(
    .DISPLAY_WIDTH      (DISP_W),
    .DISPLAY_HEIGHT     (DISP_H),
    .COLUMN_OFFSET      (COL_OFFSET),
    .CONTROLLER_COLUMNS (CTRL_COLS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Results are checked before the item of the same edge is applied. A write
  // seen at that edge can only belong to an earlier item, so the queue order
  // stays right either way, and the frame copy advances in acceptance order.
  // The watchdog counts edges where neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_write(out_data);
      if (in_valid && !in_stall) board.apply_item(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver alternates free runs with stalls of random length. The stall
  // never looks at out_valid, so stalls land on every phase of a clear.
  initial begin
    int unsigned n;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Presents one item, after an optional gap, and returns at the edge that
  // accepts it. Valid stays high into the next call when there is no gap, and
  // the payload is held steady for as long as the block stalls.
  task automatic drive_item(input logic cmd, input logic [7:0] px, input logic [7:0] py,
                            input logic clr);
    in_item_t    it;
    int unsigned gap;
    it.command = cmd;
    it.x       = px;
    it.y       = py;
    it.color   = clr;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_CLEAR) n_clear++;
    else if (px < DISP_W && py < DISP_H) n_plot++;
    else n_ignored++;
  endtask

  initial begin
    int unsigned done;
    int unsigned r;
    logic [7:0]  px;
    logic [7:0]  py;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The first six items go back to back with no gaps and no receiver stalls.
    // Two plots share one byte, so the read-modify-write keeps both bits.
    drive_item(CMD_PLOT, 8'd0, 8'd0, 1'b1);
    drive_item(CMD_PLOT, 8'd0, 8'd7, 1'b1);
    drive_item(CMD_PLOT, 8'd0, 8'd0, 1'b0);
    // The far corner of the display, the last valid column and row.
    drive_item(CMD_PLOT, 8'd95, 8'd63, 1'b1);
    drive_item(CMD_PLOT, 8'd95, 8'd56, 1'b1);
    drive_item(CMD_PLOT, 8'd95, 8'd63, 1'b0);
    calm = 1'b0;
    // Coordinates just past the edges and at the field maxima are dropped.
    drive_item(CMD_PLOT, 8'd96, 8'd0, 1'b1);
    drive_item(CMD_PLOT, 8'd0, 8'd64, 1'b1);
    drive_item(CMD_PLOT, 8'd95, 8'd64, 1'b0);
    drive_item(CMD_PLOT, 8'd96, 8'd63, 1'b0);
    drive_item(CMD_PLOT, 8'd255, 8'd255, 1'b1);
    drive_item(CMD_PLOT, 8'd127, 8'd8, 1'b1);
    // A white clear, with its unused coordinates at their maxima, then a
    // black pixel punched into the filled frame.
    drive_item(CMD_CLEAR, 8'd255, 8'd255, 1'b1);
    drive_item(CMD_PLOT, 8'd10, 8'd20, 1'b0);
    drive_item(CMD_PLOT, 8'd10, 8'd20, 1'b1);
    drive_item(CMD_PLOT, 8'd47, 8'd31, 1'b0);
    // A black clear brings the frame back to all zeros.
    drive_item(CMD_CLEAR, 8'd0, 8'd0, 1'b0);
    drive_item(CMD_PLOT, 8'd47, 8'd31, 1'b1);
    drive_item(CMD_PLOT, 8'd48, 8'd32, 1'b1);
    drive_item(CMD_PLOT, 8'd1, 8'd9, 1'b1);

    // Random part. Most items are in-range plots, half of them aimed at a
    // few columns so that bytes get rewritten many times. Clears are rare
    // since each one sweeps the whole store. The rest is full-range noise
    // that mostly falls outside the display; dropped items are not counted.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done % 25 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        drive_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
        done++;
      end else if (r < 84) begin
        px = $urandom_range(0, 1) ? 8'($urandom_range(30, 33))
                                  : 8'($urandom_range(0, DISP_W - 1));
        py = 8'($urandom_range(0, DISP_H - 1));
        drive_item(CMD_PLOT, px, py, 1'($urandom_range(0, 1)));
        done++;
      end else begin
        px = 8'($urandom_range(0, 255));
        py = 8'($urandom_range(0, 255));
        drive_item(CMD_PLOT, px, py, 1'($urandom_range(0, 1)));
        if (px < DISP_W && py < DISP_H) done++;
      end
    end
    in_valid <= 1'b0;

    // Drain every expected write; the watchdog bounds this wait. Then give
    // the block a few more cycles to show any write it should not make.
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d plots, %0d clears and %0d dropped plots",
             n_plot, n_clear, n_ignored);
    $display("%0d page writes matched, %0d mismatched", board.matched,
             board.mismatches);
    if (board.mismatches == 0 && board.pending_writes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
